>>> hdl/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, codes and types of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;
   localparam int NUM_CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(NUM_CELLS);

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int COLOR_W = 7;
   localparam int CELL_W  = COLOR_W + CHAR_W;
   localparam int POS_W   = 12;

   localparam logic [POS_W-1:0] POS_HIDDEN =
      POS_W'(SCREEN_HEIGHT * SCREEN_WIDTH + SCREEN_WIDTH);

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_SET   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7E;

   // configuration registers
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TEXT_COLOR    = 1'b0;
   localparam logic REG_CURSOR_HIDDEN = 1'b1;
   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 7'd7;

   // what one item does to the store and the cursor
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ROW_W-1:0]  acc_row;
      logic [COL_W-1:0]  acc_col;
      logic [CHAR_W-1:0] wr_char;
      logic [ROW_W-1:0]  next_row;
      logic [COL_W-1:0]  next_col;
      logic              scroll;
      logic              clear;
      logic              status;
   } cmd_type;

endpackage

>>> hdl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console engine: 80x25 character/colour cell RAM, cursor, scrolling.
// ----------------------------------------------------------------------------
// One item is worked at a time. Put byte, set cursor and clear-free items
// pass from transfer through S_EXEC and S_FINISH to the result; read cell
// adds S_RDWAIT for the registered RAM read. A put byte that runs past the
// last row adds S_BLANK, one RAM write a cycle blanking the new bottom row:
// scrolling itself is a top-row pointer into the ring of RAM rows, so no rows
// are copied. Clear screen adds S_SWEEP, one RAM write per cell. After reset a
// clearing pass fills the store with spaces before the first item is taken;
// configuration writes are taken throughout. The result register lets the
// next item in while a result waits to be taken.
// ----------------------------------------------------------------------------
module text_console_cursor_engine import tcce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [CHAR_W-1:0]     req_byte_in,
   input  logic [ROW_W-1:0]      req_row_in,
   input  logic [COL_W-1:0]      req_col_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_status,
   output logic [CHAR_W-1:0]     rsp_read_char,
   output logic [ROW_W-1:0]      rsp_cur_row,
   output logic [COL_W-1:0]      rsp_cur_col,
   output logic [POS_W-1:0]      rsp_lin_pos,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [COLOR_W-1:0] text_color_ff, text_color_in;
   logic               cursor_hidden_ff, cursor_hidden_in;
   logic               csr_wr;
   logic               reg_sel;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [CELL_W-1:0]  mem_rdata;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign reg_sel = paddr[2];

   always_comb begin
      text_color_in    = text_color_ff;
      cursor_hidden_in = cursor_hidden_ff;
      if (csr_wr) begin
         if (reg_sel == REG_TEXT_COLOR) begin
            text_color_in = pwdata[COLOR_W-1:0];
         end else begin
            cursor_hidden_in = pwdata[0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_CURSOR_HIDDEN) begin
         prdata = CSR_DATA_W'(cursor_hidden_ff);
      end else begin
         prdata = CSR_DATA_W'(text_color_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff    <= TEXT_COLOR_RESET;
         cursor_hidden_ff <= 1'b0;
      end else begin
         text_color_ff    <= text_color_in;
         cursor_hidden_ff <= cursor_hidden_in;
      end
   end

   tcce_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_byte_in    (req_byte_in),
      .req_row_in     (req_row_in),
      .req_col_in     (req_col_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_char  (rsp_read_char),
      .rsp_cur_row    (rsp_cur_row),
      .rsp_cur_col    (rsp_cur_col),
      .rsp_lin_pos    (rsp_lin_pos),
      .text_color     (text_color_ff),
      .cursor_hidden  (cursor_hidden_ff),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (NUM_CELLS)
   ) u_cells (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

>>> hdl/tcce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/tcce_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_cursor
// Decodes one item against the current cursor: cell access, next cursor,
// scroll and clear requests, status.
// ----------------------------------------------------------------------------
module tcce_cursor import tcce_pkg::*; (
   input  logic [OP_W-1:0]   op,
   input  logic [CHAR_W-1:0] byte_in,
   input  logic [ROW_W-1:0]  row_in,
   input  logic [COL_W-1:0]  col_in,
   input  logic [ROW_W-1:0]  cur_row,
   input  logic [COL_W-1:0]  cur_col,
   output cmd_type           cmd
);

   logic pos_ok;
   logic advance;

   assign pos_ok = (row_in < ROW_W'(SCREEN_HEIGHT)) && (col_in < COL_W'(SCREEN_WIDTH));

   always_comb begin
      cmd          = '0;
      cmd.acc_row  = cur_row;
      cmd.acc_col  = cur_col;
      cmd.wr_char  = CH_SPACE;
      cmd.next_row = cur_row;
      cmd.next_col = cur_col;
      advance      = 1'b0;

      case (op)
         OP_PUT: begin
            if (byte_in inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_char = byte_in;
               if (cur_col == COL_W'(SCREEN_WIDTH - 1)) begin
                  advance = 1'b1;
               end else begin
                  cmd.next_col = cur_col + 1'b1;
               end
            end else begin
               cmd.status = 1'b1;
               if (byte_in == CH_NEWLINE) begin
                  advance = 1'b1;
               end else if (byte_in == CH_RETURN) begin
                  cmd.next_col = '0;
               end else if (byte_in == CH_BACKSPACE) begin
                  if (cur_col != '0) begin
                     cmd.wr_en    = 1'b1;
                     cmd.acc_col  = cur_col - 1'b1;
                     cmd.next_col = cur_col - 1'b1;
                  end else if (cur_row != '0) begin
                     cmd.wr_en    = 1'b1;
                     cmd.acc_row  = cur_row - 1'b1;
                     cmd.acc_col  = COL_W'(SCREEN_WIDTH - 1);
                     cmd.next_row = cur_row - 1'b1;
                     cmd.next_col = COL_W'(SCREEN_WIDTH - 1);
                  end
               end
            end
         end
         OP_READ: begin
            if (pos_ok) begin
               cmd.rd_en   = 1'b1;
               cmd.acc_row = row_in;
               cmd.acc_col = col_in;
            end else begin
               cmd.status = 1'b1;
            end
         end
         OP_SET: begin
            if (pos_ok) begin
               cmd.next_row = row_in;
               cmd.next_col = col_in;
            end else begin
               cmd.status = 1'b1;
            end
         end
         default: begin
            cmd.clear    = 1'b1;
            cmd.next_row = '0;
            cmd.next_col = '0;
         end
      endcase

      // next line; on the last row the store scrolls instead
      if (advance) begin
         cmd.next_col = '0;
         if (cur_row == ROW_W'(SCREEN_HEIGHT - 1)) begin
            cmd.scroll = 1'b1;
         end else begin
            cmd.next_row = cur_row + 1'b1;
         end
      end
   end

endmodule

>>> hdl/tcce_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_seq
// Item sequencer: cursor and top-row registers, row mapping into the cell
// RAM, store sweeps for clear and scroll, result register.
// ----------------------------------------------------------------------------
module tcce_seq import tcce_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CHAR_W-1:0]   req_byte_in,
   input  logic [ROW_W-1:0]    req_row_in,
   input  logic [COL_W-1:0]    req_col_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_status,
   output logic [CHAR_W-1:0]   rsp_read_char,
   output logic [ROW_W-1:0]    rsp_cur_row,
   output logic [COL_W-1:0]    rsp_cur_col,
   output logic [POS_W-1:0]    rsp_lin_pos,
   input  logic [COLOR_W-1:0]  text_color,
   input  logic                cursor_hidden,
   output logic                mem_we,
   output logic [ADDR_W-1:0]   mem_waddr,
   output logic [CELL_W-1:0]   mem_wdata,
   output logic [ADDR_W-1:0]   mem_raddr,
   input  logic [CELL_W-1:0]   mem_rdata
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_SWEEP  = 3'd4;
   localparam logic [2:0] S_BLANK  = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]        state_ff,   state_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  top_ff,     top_in;
   logic [ADDR_W-1:0] cnt_ff,     cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [OP_W-1:0]   op_ff;
   logic [CHAR_W-1:0] byte_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              status_ff, status_in;
   logic [CHAR_W-1:0] rchar_ff, rchar_in;
   logic              rsp_status_ff;
   logic [CHAR_W-1:0] rsp_read_char_ff;
   logic [ROW_W-1:0]  rsp_cur_row_ff;
   logic [COL_W-1:0]  rsp_cur_col_ff;
   logic [POS_W-1:0]  rsp_lin_pos_ff, pos_in;

   cmd_type           cmd;
   logic [ROW_W:0]    phys_sum;
   logic [ROW_W-1:0]  phys_row;
   logic [ADDR_W-1:0] exec_addr;
   logic              req_xfer;
   logic              rsp_load;

   tcce_cursor u_cursor (
      .op      (op_ff),
      .byte_in (byte_ff),
      .row_in  (row_ff),
      .col_in  (col_ff),
      .cur_row (cur_row_ff),
      .cur_col (cur_col_ff),
      .cmd     (cmd)
   );

   // logical row to RAM row: the store is a ring of rows starting at top_ff
   assign phys_sum  = {1'b0, cmd.acc_row} + {1'b0, top_ff};
   assign phys_row  = (phys_sum >= (ROW_W + 1)'(SCREEN_HEIGHT)) ?
                      ROW_W'(phys_sum - (ROW_W + 1)'(SCREEN_HEIGHT)) : phys_sum[ROW_W-1:0];
   assign exec_addr = ADDR_W'(phys_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cmd.acc_col);

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign pos_in = cursor_hidden ? POS_HIDDEN :
                   POS_W'(cur_row_ff) * POS_W'(SCREEN_WIDTH) + POS_W'(cur_col_ff);

   always_comb begin
      state_in   = state_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      top_in     = top_ff;
      cnt_in     = cnt_ff;
      base_in    = base_ff;
      status_in  = status_ff;
      rchar_in   = rchar_ff;
      mem_we     = 1'b0;
      mem_waddr  = exec_addr;
      mem_wdata  = {text_color, cmd.wr_char};
      mem_raddr  = exec_addr;

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = {TEXT_COLOR_RESET, CH_SPACE};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(NUM_CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            mem_we     = cmd.wr_en;
            cur_row_in = cmd.next_row;
            cur_col_in = cmd.next_col;
            status_in  = cmd.status;
            rchar_in   = '0;
            cnt_in     = '0;
            if (cmd.clear) begin
               top_in   = '0;
               state_in = S_SWEEP;
            end else if (cmd.scroll) begin
               // the old top row becomes the blank bottom row
               base_in  = ADDR_W'(top_ff) * ADDR_W'(SCREEN_WIDTH);
               top_in   = (top_ff == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : top_ff + 1'b1;
               state_in = S_BLANK;
            end else if (cmd.rd_en) begin
               state_in = S_RDWAIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_RDWAIT: begin
            rchar_in = mem_rdata[CHAR_W-1:0];
            state_in = S_FINISH;
         end
         S_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = {text_color, CH_SPACE};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(NUM_CELLS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff + cnt_ff;
            mem_wdata = {text_color, CH_SPACE};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(SCREEN_WIDTH - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff   <= req_op;
         byte_ff <= req_byte_in;
         row_ff  <= req_row_in;
         col_ff  <= req_col_in;
      end
      base_ff   <= base_in;
      status_ff <= status_in;
      rchar_ff  <= rchar_in;
      if (rsp_load) begin
         rsp_status_ff     <= status_ff;
         rsp_read_char_ff  <= rchar_ff;
         rsp_cur_row_ff    <= cur_row_ff;
         rsp_cur_col_ff    <= cur_col_ff;
         rsp_lin_pos_ff    <= pos_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_char  = rsp_read_char_ff;
   assign rsp_cur_row    = rsp_cur_row_ff;
   assign rsp_cur_col    = rsp_cur_col_ff;
   assign rsp_lin_pos    = rsp_lin_pos_ff;

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff < ROW_W'(SCREEN_HEIGHT)) && (cur_col_ff < COL_W'(SCREEN_WIDTH)))
      else $error("cursor left the screen");

   a_top_in_range: assert property (@(posedge clock) disable iff (reset)
      top_ff < ROW_W'(SCREEN_HEIGHT))
      else $error("top row pointer out of range");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr < ADDR_W'(NUM_CELLS)))
      else $error("cell write beyond the store");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result transfer raised outside the finish step");

   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_EXEC))
      else $error("accepted item did not start execution");

endmodule
